// ----- design/tmv_pkg.sv -----
package tmv_pkg;

    localparam int HASH_TABLE_DEPTH_DEF  = 256;
    localparam int MAX_SECTION_WORDS_DEF = 1048576;
    localparam int MIN_RECORD_WORDS      = 6;
    localparam int CFG_IDX_W             = 1;
    localparam int SEC_W                 = 21;

    localparam logic [CFG_IDX_W-1:0] REG_SECTION_WORDS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPEMAP_KIND  = 1'd1;

    typedef enum logic [3:0] {
        PH_LEN, PH_KIND, PH_HASH, PH_STRIDE, PH_NFIXED, PH_FIXED, PH_NVAR,
        PH_SEL, PH_NARMS, PH_ASEL, PH_NOFF, PH_OFF, PH_SKIP
    } phase_t;

    typedef enum logic [3:0] {
        ROLE_PAD, ROLE_LEN, ROLE_KIND, ROLE_HASH, ROLE_STRIDE, ROLE_NFIXED,
        ROLE_FIXED, ROLE_NVAR, ROLE_SEL, ROLE_NARMS, ROLE_ASEL, ROLE_NOFF,
        ROLE_OFF, ROLE_SKIP, ROLE_IGNORED
    } role_t;

    typedef enum logic [3:0] {
        ST_NONE, ST_ACCEPTED, ST_UNKNOWN, ST_DUPLICATE, ST_BAD_LEN,
        ST_FIXED_OVERRUN, ST_NO_VARIANTS, ST_MALFORMED, ST_TABLE_FULL
    } status_t;

    // lookup request travelling down the cell row
    typedef struct packed {
        logic        look;
        logic        store;
        logic [63:0] hash;
    } hreq_t;

endpackage

// ----- design/tmv_hash_cell.sv -----
module tmv_hash_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  tmv_pkg::hreq_t req_i,
    input  logic          hit_i,
    input  logic          store_here_i,
    input  logic [63:0]   store_hash_i,
    output tmv_pkg::hreq_t req_o,
    output logic          hit_o
);
    import tmv_pkg::*;

    logic        valid_reg;
    logic [63:0] hash_reg;
    hreq_t       req_reg;
    logic        hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            req_reg   <= '0;
            hit_reg   <= 1'b0;
        end else begin
            req_reg <= req_i;
            hit_reg <= hit_i | (req_i.look & valid_reg & (hash_reg == req_i.hash));
            if (store_here_i) begin
                valid_reg <= 1'b1;
                hash_reg  <= store_hash_i;
            end
        end
    end

    assign req_o = req_reg;
    assign hit_o = hit_reg;
endmodule

// ----- design/tmv_hash_table.sv -----
module tmv_hash_table #(
    parameter int DEPTH = tmv_pkg::HASH_TABLE_DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             look_i,
    input  logic [63:0]      hash_i,
    input  logic             store_i,
    input  logic [CNT_W-1:0] slot_i,
    output logic             done_o,
    output logic             hit_o
);
    import tmv_pkg::*;

    hreq_t req_w [DEPTH+1];
    logic  hit_w [DEPTH+1];

    assign req_w[0] = '{look: look_i, store: store_i, hash: hash_i};
    assign hit_w[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic here;
        assign here = store_i && (slot_i == CNT_W'(g));
        tmv_hash_cell u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .req_i(g == 0 ? req_w[0] : req_w[g]), .hit_i(hit_w[g]),
            .store_here_i(here), .store_hash_i(hash_i),
            .req_o(req_w[g+1]), .hit_o(hit_w[g+1])
        );
    end

    assign done_o = req_w[DEPTH].look;
    assign hit_o  = hit_w[DEPTH];
endmodule

// ----- design/typemap_record_stream_validator.sv -----
// Type-map record stream validator. Write section_words (index 0) and
// typemap_kind (index 1) while idle; writing section_words rearms the parser.
// One output beat per input beat, in order. Each word is parsed into the
// result register and leaves from there; a hash word first walks the row of
// HASH_TABLE_DEPTH compare cells, one cell a cycle, before it is parsed.
// cfg_ready is low while a hash word is in the row, and s_ready is low while
// a register write is offered. The table is held in per-cell valid bits,
// cleared at reset, kept across sections.
module typemap_record_stream_validator #(
    parameter int HASH_TABLE_DEPTH  = tmv_pkg::HASH_TABLE_DEPTH_DEF,
    parameter int MAX_SECTION_WORDS = tmv_pkg::MAX_SECTION_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tmv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [63:0]                   s_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_word_role,
    output logic [63:0]                   m_word_value,
    output logic [19:0]                   m_variant_index,
    output logic [19:0]                   m_arm_index,
    output logic [3:0]                    m_record_status,
    output logic                          m_section_last,
    output logic                          m_section_ok
);
    import tmv_pkg::*;

    localparam int CNT_W = $clog2(HASH_TABLE_DEPTH + 1);
    // saturation limit, capped at what the register can hold
    localparam int SW_CAP = (MAX_SECTION_WORDS > (1 << SEC_W) - 1) ? (1 << SEC_W) - 1
                            : MAX_SECTION_WORDS;
    localparam logic [SEC_W-1:0] MAX_SW = SEC_W'(SW_CAP);

    // configuration and parse state
    logic [SEC_W-1:0] sec_words_reg, words_seen_reg, rwl_reg, rwl_next;
    logic [63:0]      kind_reg, hash_reg, hash_next;
    phase_t           phase_reg, phase_next;
    logic [SEC_W-1:0] fixed_reg, fixed_next, offs_reg, offs_next;
    logic [63:0]      vars_reg, vars_next, arms_reg, arms_next;
    logic [SEC_W-1:0] vcnt_reg, vcnt_next, acnt_reg, acnt_next;
    logic             err_reg, err_next;
    logic [CNT_W-1:0] seen_reg;
    logic             store;

    // hash word waiting on the cell row
    logic             busy_reg;
    logic [63:0]      hw_reg;
    logic             t_done, t_hit;

    // result register
    logic             mv_reg;
    logic [3:0]       role_reg, st_reg;
    logic [63:0]      val_reg;
    logic [19:0]      vi_reg, ai_reg;
    logic             last_reg, ok_reg;

    logic             take, process, active;
    logic [63:0]      w;
    role_t            role;
    status_t          st;
    logic [19:0]      vi, ai;
    logic [SEC_W-1:0] rwl_d, avail;

    // register writes wait for the row to empty and never meet an input beat
    assign cfg_ready = !busy_reg;
    assign s_ready   = !busy_reg && !cfg_valid && (!mv_reg || m_ready);
    assign take      = s_valid && s_ready;
    assign active    = words_seen_reg < sec_words_reg;
    // a hash word parses only once the row has answered
    assign process   = (take && !(active && !err_reg && phase_reg == PH_HASH)) ||
                       (busy_reg && t_done);
    assign w         = busy_reg ? hw_reg : s_word;

    // the row is looked up with the incoming word and filled with the pending hash
    tmv_hash_table #(.DEPTH(HASH_TABLE_DEPTH), .CNT_W(CNT_W)) u_table (
        .aclk(aclk), .aresetn(aresetn),
        .look_i(take && active && !err_reg && phase_reg == PH_HASH),
        .hash_i(store ? hash_reg : s_word), .store_i(store), .slot_i(seen_reg),
        .done_o(t_done), .hit_o(t_hit)
    );

    always_comb begin
        role = ROLE_IGNORED; st = ST_NONE; vi = '0; ai = '0;
        rwl_next = rwl_reg; phase_next = phase_reg; hash_next = hash_reg;
        fixed_next = fixed_reg; offs_next = offs_reg; vars_next = vars_reg;
        arms_next = arms_reg; vcnt_next = vcnt_reg; acnt_next = acnt_reg;
        err_next = err_reg; store = 1'b0;
        avail = sec_words_reg - words_seen_reg;
        rwl_d = (phase_reg != PH_LEN && rwl_reg != '0) ? rwl_reg - 1'b1 : rwl_reg;
        if (active && !err_reg) begin
            rwl_next = rwl_d;
            unique case (phase_reg)
                PH_LEN: begin
                    if (w == 64'd0) begin
                        role = ROLE_PAD;
                    end else begin
                        role = ROLE_LEN;
                        if (w < 64'(MIN_RECORD_WORDS) || w > 64'(avail)) begin
                            st = ST_BAD_LEN; err_next = 1'b1;
                        end else begin
                            rwl_next = w[SEC_W-1:0] - 1'b1;
                            phase_next = PH_KIND;
                        end
                    end
                end
                PH_KIND: begin
                    role = ROLE_KIND;
                    if (w != kind_reg) begin
                        st = ST_UNKNOWN; phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_HASH;
                    end
                end
                PH_HASH: begin
                    role = ROLE_HASH; hash_next = w;
                    if (t_hit) begin
                        st = ST_DUPLICATE; phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_STRIDE;
                    end
                end
                PH_STRIDE: begin
                    role = ROLE_STRIDE; phase_next = PH_NFIXED;
                end
                PH_NFIXED: begin
                    role = ROLE_NFIXED;
                    if (w > 64'(rwl_d)) begin
                        st = ST_FIXED_OVERRUN; err_next = 1'b1;
                    end else if (w == 64'(rwl_d)) begin
                        st = ST_NO_VARIANTS; err_next = 1'b1;
                    end else begin
                        fixed_next = w[SEC_W-1:0];
                        phase_next = (w != 64'd0) ? PH_FIXED : PH_NVAR;
                    end
                end
                PH_FIXED: begin
                    role = ROLE_FIXED;
                    if (fixed_reg <= SEC_W'(1)) phase_next = PH_NVAR;
                    if (fixed_reg != '0) fixed_next = fixed_reg - 1'b1;
                end
                PH_SEL: begin
                    role = ROLE_SEL; vi = vcnt_reg[19:0]; phase_next = PH_NARMS;
                end
                PH_ASEL: begin
                    role = ROLE_ASEL; vi = vcnt_reg[19:0]; ai = acnt_reg[19:0];
                    phase_next = PH_NOFF;
                end
                PH_SKIP: begin
                    role = ROLE_SKIP;
                    if (rwl_d == '0) phase_next = PH_LEN;
                end
                default: begin
                    // variant count, arm count, offset count, arm offset:
                    // these share the end-of-arm / end-of-variant chain
                    logic arm_end, arms_chk, var_end, vars_chk;
                    logic [63:0] a, v;
                    arm_end = 1'b0; arms_chk = 1'b0; var_end = 1'b0; vars_chk = 1'b0;
                    a = arms_reg; v = vars_reg;
                    unique case (phase_reg)
                        PH_NVAR: begin
                            role = ROLE_NVAR; v = w; vcnt_next = '0; vars_chk = 1'b1;
                        end
                        PH_NARMS: begin
                            role = ROLE_NARMS; vi = vcnt_reg[19:0];
                            a = w; acnt_next = '0; arms_chk = 1'b1;
                        end
                        PH_NOFF: begin
                            role = ROLE_NOFF; vi = vcnt_reg[19:0]; ai = acnt_reg[19:0];
                            if (w > 64'(rwl_d)) begin
                                st = ST_MALFORMED; err_next = 1'b1;
                            end else begin
                                offs_next = w[SEC_W-1:0];
                                if (w == 64'd0) arm_end = 1'b1;
                                else phase_next = PH_OFF;
                            end
                        end
                        default: begin
                            role = ROLE_OFF; vi = vcnt_reg[19:0]; ai = acnt_reg[19:0];
                            if (offs_reg != '0) offs_next = offs_reg - 1'b1;
                            if (offs_reg <= SEC_W'(1)) arm_end = 1'b1;
                        end
                    endcase
                    if (arm_end) begin
                        a = arms_reg - 64'd1;
                        acnt_next = acnt_reg + 1'b1;
                        arms_chk = 1'b1;
                    end
                    if (arms_chk) begin
                        if (a == 64'd0) begin
                            v = vars_reg - 64'd1;
                            vcnt_next = vcnt_reg + 1'b1;
                            vars_chk = 1'b1;
                        end else if (rwl_d < SEC_W'(2)) begin
                            st = ST_MALFORMED; err_next = 1'b1;
                        end else begin
                            phase_next = PH_ASEL;
                        end
                    end
                    if (vars_chk) begin
                        if (v == 64'd0) var_end = 1'b1;
                        else if (rwl_d < SEC_W'(2)) begin
                            st = ST_MALFORMED; err_next = 1'b1;
                        end else phase_next = PH_SEL;
                    end
                    if (var_end) begin
                        if (rwl_d != '0) begin
                            st = ST_MALFORMED; err_next = 1'b1;
                        end else begin
                            phase_next = PH_LEN;
                            if (seen_reg >= CNT_W'(HASH_TABLE_DEPTH)) st = ST_TABLE_FULL;
                            else begin
                                st = ST_ACCEPTED; store = process;
                            end
                        end
                    end
                    arms_next = a; vars_next = v;
                end
            endcase
            if (err_next && !err_reg) phase_next = PH_LEN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_words_reg <= '0; kind_reg <= 64'd1; seen_reg <= '0;
            words_seen_reg <= '0; rwl_reg <= '0; phase_reg <= PH_LEN;
            hash_reg <= '0; fixed_reg <= '0; offs_reg <= '0; vars_reg <= '0;
            arms_reg <= '0; vcnt_reg <= '0; acnt_reg <= '0; err_reg <= 1'b0;
            busy_reg <= 1'b0; mv_reg <= 1'b0;
        end else begin
            if (take && !process) begin
                busy_reg <= 1'b1; hw_reg <= s_word;
            end
            if (process) begin
                busy_reg <= 1'b0;
                if (active) words_seen_reg <= words_seen_reg + 1'b1;
                rwl_reg <= rwl_next; phase_reg <= phase_next; hash_reg <= hash_next;
                fixed_reg <= fixed_next; offs_reg <= offs_next;
                vars_reg <= vars_next; arms_reg <= arms_next;
                vcnt_reg <= vcnt_next; acnt_reg <= acnt_next; err_reg <= err_next;
                if (store) seen_reg <= seen_reg + 1'b1;
                mv_reg   <= 1'b1;
                role_reg <= role; st_reg <= st; val_reg <= w;
                vi_reg <= vi; ai_reg <= ai;
                last_reg <= active && (words_seen_reg + 1'b1 == sec_words_reg);
                // an error raised by the final word itself clears ok
                ok_reg   <= active && (words_seen_reg + 1'b1 == sec_words_reg) && !err_next;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SECTION_WORDS) begin
                    sec_words_reg <= (cfg_data[SEC_W-1:0] > MAX_SW) ? MAX_SW
                                     : cfg_data[SEC_W-1:0];
                    words_seen_reg <= '0; rwl_reg <= '0; phase_reg <= PH_LEN;
                    hash_reg <= '0; fixed_reg <= '0; offs_reg <= '0;
                    vars_reg <= '0; arms_reg <= '0; vcnt_reg <= '0;
                    acnt_reg <= '0; err_reg <= 1'b0;
                end else begin
                    kind_reg <= cfg_data;
                end
            end
        end
    end

    assign m_valid = mv_reg;
    assign m_word_role = role_reg;
    assign m_word_value = val_reg;
    assign m_variant_index = vi_reg;
    assign m_arm_index = ai_reg;
    assign m_record_status = st_reg;
    assign m_section_last = last_reg;
    assign m_section_ok = ok_reg;
endmodule

// ----- design/tmv_checker.sv -----
module tmv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_word_role,
    input logic [3:0]  m_record_status,
    input logic        m_section_last,
    input logic        m_section_ok
);
    import tmv_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word_role))
        else $error("result beat dropped while stalled");
    a_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_section_ok |-> m_section_last)
        else $error("section ok off the last beat");
    a_role: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word_role <= 4'(ROLE_IGNORED))
        else $error("role out of range");
    a_st: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word_role == 4'(ROLE_IGNORED) |-> m_record_status == 4'(ST_NONE))
        else $error("status on ignored word");
endmodule

bind typemap_record_stream_validator tmv_checker u_tmv_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_word_role(m_word_role), .m_record_status(m_record_status),
    .m_section_last(m_section_last), .m_section_ok(m_section_ok)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tmv_pkg::*;

    localparam int TAB_DEPTH  = 256;
    localparam int MAX_SEC    = 1048576;
    // a hash word walks the whole compare row before it leaves
    localparam int DRAIN_WAIT = TAB_DEPTH + 16;

    // one tagged word as it leaves the block
    typedef struct packed {
        logic [3:0]  role;
        logic [63:0] value;
        logic [19:0] vidx;
        logic [19:0] aidx;
        logic [3:0]  status;
        logic        last;
        logic        ok;
    } tag_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [63:0]          s_word;
    logic                 m_valid;
    logic                 m_ready;
    logic [3:0]           m_word_role;
    logic [63:0]          m_word_value;
    logic [19:0]          m_variant_index;
    logic [19:0]          m_arm_index;
    logic [3:0]           m_record_status;
    logic                 m_section_last;
    logic                 m_section_ok;

    typemap_record_stream_validator i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_word          (s_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_word_role     (m_word_role),
        .m_word_value    (m_word_value),
        .m_variant_index (m_variant_index),
        .m_arm_index     (m_arm_index),
        .m_record_status (m_record_status),
        .m_section_last  (m_section_last),
        .m_section_ok    (m_section_ok)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // tagging model state
    logic [20:0] sec_len;
    logic [63:0] kind_cfg;
    logic [20:0] wseen;
    logic [63:0] rec_left;
    phase_t      phase;
    logic [63:0] pend_kind;
    logic [63:0] pend_hash;
    logic [63:0] fix_left;
    logic [63:0] var_left;
    logic [63:0] arm_left;
    logic [63:0] off_left;
    logic [20:0] var_ctr;
    logic [20:0] arm_ctr;
    logic        err_lat;
    logic [63:0] hash_tab [TAB_DEPTH];
    int          hash_cnt;

    tag_t        tags_due [$];
    int          mismatches;
    int          words_sent;
    int          idle_pct;
    int          stall_pct;
    int          hold_off;

    function automatic status_t fail_rec(input status_t code);
        err_lat = 1'b1;
        phase   = PH_LEN;
        return code;
    endfunction

    function automatic status_t close_record();
        if (rec_left != 0) return fail_rec(ST_MALFORMED);
        phase = PH_LEN;
        if (hash_cnt >= TAB_DEPTH) return ST_TABLE_FULL;
        hash_tab[hash_cnt] = pend_hash;
        hash_cnt++;
        return ST_ACCEPTED;
    endfunction

    function automatic status_t next_variant();
        if (var_left == 0) return close_record();
        if (rec_left < 2) return fail_rec(ST_MALFORMED);
        phase = PH_SEL;
        return ST_NONE;
    endfunction

    function automatic status_t next_arm();
        if (arm_left == 0) begin
            var_left--;
            var_ctr++;
            return next_variant();
        end
        if (rec_left < 2) return fail_rec(ST_MALFORMED);
        phase = PH_ASEL;
        return ST_NONE;
    endfunction

    function automatic status_t arm_finished();
        arm_left--;
        arm_ctr++;
        return next_arm();
    endfunction

    function automatic logic hash_known(input logic [63:0] h);
        for (int i = 0; i < hash_cnt && i < TAB_DEPTH; i++)
            if (hash_tab[i] == h) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void rearm_parser();
        wseen     = '0;
        rec_left  = '0;
        phase     = PH_LEN;
        pend_kind = '0;
        pend_hash = '0;
        fix_left  = '0;
        var_left  = '0;
        arm_left  = '0;
        off_left  = '0;
        var_ctr   = '0;
        arm_ctr   = '0;
        err_lat   = 1'b0;
    endfunction

    function automatic tag_t tag_word(input logic [63:0] w);
        tag_t    t;
        status_t st;
        role_t   role;
        logic    active;
        st     = ST_NONE;
        role   = ROLE_IGNORED;
        t      = '0;
        active = wseen < sec_len;
        if (active && !err_lat) begin
            if (phase != PH_LEN && rec_left > 0) rec_left--;
            case (phase)
                PH_LEN: begin
                    if (w == 0) begin
                        role = ROLE_PAD;
                    end else begin
                        role = ROLE_LEN;
                        if (w < MIN_RECORD_WORDS || w > {43'd0, sec_len - wseen}) begin
                            st = fail_rec(ST_BAD_LEN);
                        end else begin
                            rec_left = w - 1;
                            phase    = PH_KIND;
                        end
                    end
                end
                PH_KIND: begin
                    role      = ROLE_KIND;
                    pend_kind = w;
                    if (w != kind_cfg) begin
                        st    = ST_UNKNOWN;
                        phase = PH_SKIP;
                    end else begin
                        phase = PH_HASH;
                    end
                end
                PH_HASH: begin
                    role      = ROLE_HASH;
                    pend_hash = w;
                    if (hash_known(w)) begin
                        st    = ST_DUPLICATE;
                        phase = PH_SKIP;
                    end else begin
                        phase = PH_STRIDE;
                    end
                end
                PH_STRIDE: begin
                    role  = ROLE_STRIDE;
                    phase = PH_NFIXED;
                end
                PH_NFIXED: begin
                    role = ROLE_NFIXED;
                    if (w > rec_left) st = fail_rec(ST_FIXED_OVERRUN);
                    else if (w == rec_left) st = fail_rec(ST_NO_VARIANTS);
                    else begin
                        fix_left = w;
                        phase    = (w != 0) ? PH_FIXED : PH_NVAR;
                    end
                end
                PH_FIXED: begin
                    role = ROLE_FIXED;
                    if (fix_left > 0) fix_left--;
                    if (fix_left == 0) phase = PH_NVAR;
                end
                PH_NVAR: begin
                    role     = ROLE_NVAR;
                    var_left = w;
                    var_ctr  = '0;
                    st       = next_variant();
                end
                PH_SEL: begin
                    role   = ROLE_SEL;
                    t.vidx = var_ctr[19:0];
                    phase  = PH_NARMS;
                end
                PH_NARMS: begin
                    role     = ROLE_NARMS;
                    t.vidx   = var_ctr[19:0];
                    arm_left = w;
                    arm_ctr  = '0;
                    st       = next_arm();
                end
                PH_ASEL: begin
                    role   = ROLE_ASEL;
                    t.vidx = var_ctr[19:0];
                    t.aidx = arm_ctr[19:0];
                    phase  = PH_NOFF;
                end
                PH_NOFF: begin
                    role   = ROLE_NOFF;
                    t.vidx = var_ctr[19:0];
                    t.aidx = arm_ctr[19:0];
                    if (w > rec_left) begin
                        st = fail_rec(ST_MALFORMED);
                    end else begin
                        off_left = w;
                        if (w == 0) st = arm_finished();
                        else phase = PH_OFF;
                    end
                end
                PH_OFF: begin
                    role   = ROLE_OFF;
                    t.vidx = var_ctr[19:0];
                    t.aidx = arm_ctr[19:0];
                    if (off_left > 0) off_left--;
                    if (off_left == 0) st = arm_finished();
                end
                default: begin
                    role = ROLE_SKIP;
                    if (rec_left == 0) phase = PH_LEN;
                end
            endcase
        end
        if (active) begin
            wseen++;
            t.last = (wseen == sec_len);
            t.ok   = t.last && !err_lat;
        end
        t.role   = role;
        t.status = st;
        t.value  = w;
        return t;
    endfunction

    // result side: random stall, long hold-off on request, in-order compare
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_off > 0) begin
                hold_off = hold_off - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
            if (m_valid && m_ready) begin
                if (tags_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: role %0d value %h",
                                 m_word_role, m_word_value);
                end else begin
                    tag_t want;
                    tag_t got;
                    want = tags_due.pop_front();
                    got  = {m_word_role, m_word_value, m_variant_index, m_arm_index,
                            m_record_status, m_section_last, m_section_ok};
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected role %0d val %h v %0d a %0d",
                                     want.role, want.value, want.vidx, want.aidx,
                                     " st %0d l %b ok %b,", want.status, want.last,
                                     want.ok,
                                     " got role %0d val %h v %0d a %0d",
                                     got.role, got.value, got.vidx, got.aidx,
                                     " st %0d l %b ok %b", got.status, got.last,
                                     got.ok);
                    end
                end
            end
        end
    end

    task automatic send_word(input logic [63:0] w);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        tags_due.push_back(tag_word(w));
        words_sent++;
    endtask

    // let every beat come out, then give the compare row time to empty
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tags_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
        logic [63:0] v;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SECTION_WORDS) begin
            v = d & 64'h1F_FFFF;
            if (v > MAX_SEC) v = MAX_SEC;
            sec_len = v[20:0];
            rearm_parser();
        end else begin
            kind_cfg = d;
        end
    endtask

    // record body with random content; count words kept small
    task automatic build_record(input logic [63:0] kind, input logic [63:0] hash,
                                input int nfix, input int nvar, input int max_arms,
                                input int max_offs, inout logic [63:0] q [$]);
        logic [63:0] body [$];
        int          na;
        int          no;
        body.push_back(kind);
        body.push_back(hash);
        body.push_back({$urandom, $urandom});
        body.push_back(64'(nfix));
        for (int i = 0; i < nfix; i++) body.push_back({$urandom, $urandom});
        body.push_back(64'(nvar));
        for (int v = 0; v < nvar; v++) begin
            body.push_back({$urandom, $urandom});
            na = $urandom_range(max_arms);
            body.push_back(64'(na));
            for (int a = 0; a < na; a++) begin
                body.push_back({$urandom, $urandom});
                no = $urandom_range(max_offs);
                body.push_back(64'(no));
                for (int k = 0; k < no; k++) body.push_back({$urandom, $urandom});
            end
        end
        q.push_back(64'(body.size() + 1));
        foreach (body[i]) q.push_back(body[i]);
    endtask

    task automatic run_section(input logic [63:0] words [$], input int len);
        write_reg(REG_SECTION_WORDS, 64'(len));
        foreach (words[i]) send_word(words[i]);
        drain();
    endtask

    task automatic test_directed();
        logic [63:0] q [$];
        int          mark;
        idle_pct  = 0;
        stall_pct = 0;
        // words before any section are ignored
        send_word(64'h1234);
        send_word('1);
        drain();
        // padding, a clean record, its duplicate, an unknown kind
        q = {64'd0, 64'd0};
        build_record(64'd1, 64'hDEAD_BEEF_0000_0001, 2, 2, 2, 2, q);
        build_record(64'd1, 64'hDEAD_BEEF_0000_0001, 1, 1, 1, 1, q);
        build_record(64'd7, 64'h55, 0, 1, 1, 1, q);
        q.push_back(64'd0);
        run_section(q, q.size());
        // kind extremes
        write_reg(REG_TYPEMAP_KIND, '1);
        q = {};
        build_record('1, '1, 0, 0, 0, 0, q);
        run_section(q, q.size());
        write_reg(REG_TYPEMAP_KIND, 64'd0);
        q = {};
        build_record(64'd0, 64'd0, 0, 3, 3, 3, q);
        build_record(64'd1, 64'd9, 0, 0, 0, 0, q);
        run_section(q, q.size());
        write_reg(REG_TYPEMAP_KIND, 64'd1);
        // length under the minimum, then the rest of the section is ignored
        q = {64'd5, 64'd1, '1};
        run_section(q, q.size());
        // length beyond the section end
        q = {};
        build_record(64'd1, 64'h77, 0, 0, 0, 0, q);
        run_section(q, q.size() - 1);
        // fixed count past the record end, and leaving no room for variants
        q = {};
        build_record(64'd1, 64'h78, 0, 0, 0, 0, q);
        q[4] = 64'd2;
        run_section(q, q.size());
        q = {};
        build_record(64'd1, 64'h79, 0, 0, 0, 0, q);
        q[4] = 64'd1;
        run_section(q, q.size());
        // words left over after the last variant
        q = {};
        build_record(64'd1, 64'h7A, 0, 0, 0, 0, q);
        q[0] = q[0] + 1;
        q.push_back(64'd3);
        run_section(q, q.size());
        // variant count with too few words for a variant header
        q = {};
        build_record(64'd1, 64'h7B, 0, 0, 0, 0, q);
        q[5] = 64'd1;
        run_section(q, q.size());
        // arm count with too few words left for an arm header
        q = {64'd9, 64'd1, 64'h7C, 64'd0, 64'd0, 64'd1, 64'd0, 64'd1, 64'd0, 64'd9};
        run_section(q, q.size());
        // section length zero, then saturated, then rearm cuts it short
        q = {64'd6, 64'd1};
        run_section(q, 0);
        write_reg(REG_SECTION_WORDS, 64'hFFFF_FFFF_FFFF_FFFF);
        mark = 0;
        repeat (4) begin
            send_word(mark == 0 ? 64'd0 : {$urandom, $urandom});
            mark++;
        end
        drain();
    endtask

    task automatic test_random();
        logic [63:0] q [$];
        logic [63:0] kinds [4];
        int          n;
        int          extra;
        int          mode;
        int          pos;
        kinds = '{64'd1, 64'd0, '1, {$urandom, $urandom}};
        mode  = 0;
        // random sections until 450 beats have been sent; the table fill follows
        while (words_sent < 450) begin
            case (mode % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            mode++;
            if ($urandom_range(3) == 0)
                write_reg(REG_TYPEMAP_KIND, kinds[$urandom_range(3)]);
            q = {};
            n = $urandom_range(4, 1);
            for (int r = 0; r < n; r++) begin
                if ($urandom_range(3) == 0) q.push_back(64'd0);
                build_record(($urandom_range(9) == 0) ? {$urandom, $urandom} : kind_cfg,
                             ($urandom_range(2) == 0) ? {$urandom, $urandom}
                                                      : 64'(100 + $urandom_range(40)),
                             $urandom_range(3), $urandom_range(3), 2, 3, q);
            end
            // a share of broken sections and plain noise
            if ($urandom_range(9) == 0) begin
                pos    = $urandom_range(q.size() - 1);
                q[pos] = ($urandom_range(1) == 0) ? {$urandom, $urandom}
                                                  : 64'($urandom_range(12));
            end
            if ($urandom_range(19) == 0)
                for (int k = 0; k < 6; k++) q.push_back({$urandom, $urandom});
            extra = ($urandom_range(5) == 0) ? $urandom_range(3) : 0;
            // length carries random bits above the 21 that count
            write_reg(REG_SECTION_WORDS,
                      {$urandom, 11'($urandom), 21'(q.size() - extra)});
            // one long hold-off while the sender keeps offering beats
            if (mode == 3) hold_off = 600;
            foreach (q[i]) send_word(q[i]);
            drain();
        end
    endtask

    // fill the table with minimal records, then one section past full
    task automatic test_table_full();
        logic [63:0] q [$];
        int          id;
        int          n_rec;
        logic        full_seen;
        idle_pct  = 0;
        stall_pct = 0;
        write_reg(REG_TYPEMAP_KIND, 64'd1);
        id        = 0;
        full_seen = 1'b0;
        while (!full_seen) begin
            full_seen = (hash_cnt >= TAB_DEPTH);
            n_rec     = full_seen ? 8 : 16;
            q = {};
            repeat (n_rec) begin
                build_record(64'd1, {32'hF00D_0000, 32'(id)}, 0, 0, 0, 0, q);
                id++;
            end
            run_section(q, q.size());
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_word     = '0;
        mismatches = 0;
        words_sent = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_off   = 0;
        sec_len    = '0;
        kind_cfg   = 64'd1;
        hash_cnt   = 0;
        foreach (hash_tab[i]) hash_tab[i] = '0;
        rearm_parser();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_table_full();
        if (mismatches == 0 && tags_due.size() == 0) begin
            $display("typemap_record_stream_validator verification clean");
        end else begin
            $display("typemap_record_stream_validator verification failed");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #60ms;
        $display("typemap_record_stream_validator verification failed");
        $finish;
    end

endmodule
